// File: hdl/bfdh_pkg.sv
// shared types, constants and helpers for the bloom filter engine
`default_nettype none
package bfdh_pkg;

    // default sizing handed to the top level parameters
    localparam int STORE_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF = 16;

    // field widths
    localparam int HASH_W  = 64;
    localparam int SIZE_W  = 17;
    localparam int NHASH_W = 5;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;

    // remainder unit: bits retired per cycle and steps per remainder
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = HASH_W / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // register indexes of the configuration port
    localparam logic REG_FILT_SIZE = 1'b0;
    localparam logic REG_PROBE_NUM = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_COUNT  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] set_count;
    } out_word_t;

    // queued job, classified by the front end
    typedef struct packed {
        cmd_t              cmd;
        logic              probe;
        logic              insert;
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
    } job_t;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_CLEAR,
        ST_COUNT,
        ST_COUNT_LAST
    } back_state_t;

    // number of set bits in one store word, summed as a balanced tree
    function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] s [WORD_W];
        for (int i = 0; i < WORD_W; i++)
        begin
            s[i] = {{BIT_W{1'b0}}, w[i]};
        end
        for (int span = WORD_W >> 1; span >= 1; span = span >> 1)
        begin
            for (int i = 0; i < span; i++)
            begin
                s[i] = s[2*i] + s[2*i+1];
            end
        end
        return s[0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/bfdh_front.sv
// front end: accepts words, classifies the command and queues jobs
`default_nettype none
module bfdh_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bfdh_pkg::in_word_t in_word,
    input  wire logic              init_busy,
    output logic                   job_valid,
    output bfdh_pkg::job_t         job,
    input  wire logic              job_pop
);
    import bfdh_pkg::*;

    job_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    job_t       job_in;

    // classify the incoming command
    always_comb
    begin
        job_in.cmd    = in_word.cmd;
        job_in.probe  = (in_word.cmd == CMD_INSERT) || (in_word.cmd == CMD_QUERY);
        job_in.insert = (in_word.cmd == CMD_INSERT);
        job_in.hash_a = in_word.hash_a;
        job_in.hash_b = in_word.hash_b;
    end

    // no words taken while the store is swept after reset
    assign in_stall  = (count_reg == 2'd2) || init_busy;
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

    // queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (job_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, job_pop};
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue fill did not drop after pop");
`endif
endmodule
`default_nettype wire

// File: hdl/bfdh_mod.sv
// serial remainder unit: 64-bit value modulo a 17-bit size
`default_nettype none
module bfdh_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bfdh_pkg::HASH_W-1:0]   dividend,
    input  wire logic [bfdh_pkg::SIZE_W-1:0]   divisor,
    output logic                               done,
    output logic [bfdh_pkg::SIZE_W-1:0]        rem
);
    import bfdh_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [HASH_W-1:0] quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [HASH_W-1:0] quo_next;
    logic [SIZE_W-1:0] rem_next;

    // restoring steps, DIV_BITS dividend bits a cycle
    always_comb
    begin
        logic [SIZE_W:0] t;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            t = {rem_next, quo_next[HASH_W-1]};
            quo_next = {quo_next[HASH_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            rem_next = t[SIZE_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/bfdh_back.sv
// back end: probe sequencer, bit store, clear and count sweeps, result register
`default_nettype none
module bfdh_back #(
    parameter int STORE_BITS = bfdh_pkg::STORE_BITS_DEF,
    parameter int MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bfdh_pkg::SIZE_W-1:0]   filt_size,
    input  wire logic [bfdh_pkg::NHASH_W-1:0]  probe_num,
    input  wire logic                          job_valid,
    input  wire bfdh_pkg::job_t                job,
    output logic                               job_pop,
    output logic                               init_busy,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bfdh_pkg::out_word_t                out_word
);
    import bfdh_pkg::*;

    localparam int WORDS = (STORE_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = ($clog2(STORE_BITS + 1) > SIZE_W) ? $clog2(STORE_BITS + 1) : SIZE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [HASH_W-1:0]  h_reg;
    logic [HASH_W-1:0]  stride_reg;
    logic [NHASH_W-1:0] probe_reg;
    logic               all_reg;
    logic               ins_reg;
    logic [SIZE_W-1:0]  pos_reg;
    logic [AW-1:0]      addr_reg;
    logic [CW-1:0]      acc_reg;
    logic               dv_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic [SIZE_W-1:0]  m_eff;
    logic [NHASH_W-1:0] k_last;
    logic               div_start;
    logic               div_done;
    logic [SIZE_W-1:0]  div_rem;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               out_load;
    out_word_t          out_new;
    logic               probe_bit;
    logic [CW-1:0]      acc_sum;

    // effective modulus and probe count
    always_comb
    begin
        if (filt_size == '0)
        begin
            m_eff = SIZE_W'(1);
        end
        else if (int'(filt_size) > STORE_BITS)
        begin
            m_eff = SIZE_W'(STORE_BITS);
        end
        else
        begin
            m_eff = filt_size;
        end
        if (probe_num == '0)
        begin
            k_last = '0;
        end
        else if (int'(probe_num) > MAX_HASHES)
        begin
            k_last = NHASH_W'(MAX_HASHES - 1);
        end
        else
        begin
            k_last = probe_num - 1'b1;
        end
    end

    bfdh_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (h_reg),
        .divisor  (m_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign probe_bit = rd_data_reg[pos_reg[BIT_W-1:0]];
    assign acc_sum   = acc_reg + CW'(popcount(rd_data_reg));

    // sequencer next state and controls
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = '0;
        out_load   = 1'b0;
        out_new    = '0;
        unique case (state_reg)
            ST_INIT_CLR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    job_pop = 1'b1;
                    if (job.probe)
                    begin
                        state_next = ST_DIV_START;
                    end
                    else if (job.cmd == CMD_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(div_rem >> BIT_W);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                wr_en   = ins_reg;
                wr_addr = AW'(pos_reg >> BIT_W);
                wr_data = rd_data_reg | (WORD_W'(1) << pos_reg[BIT_W-1:0]);
                if (probe_reg == k_last)
                begin
                    out_load      = 1'b1;
                    out_new.found = !ins_reg && all_reg && probe_bit;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                rd_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_COUNT_LAST;
                end
            end
            ST_COUNT_LAST:
            begin
                out_load          = 1'b1;
                out_new.set_count = acc_sum[SIZE_W-1:0];
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // bit store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // probe datapath
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            h_reg      <= job.hash_a;
            stride_reg <= job.hash_b;
            probe_reg  <= '0;
            all_reg    <= 1'b1;
            ins_reg    <= job.insert;
            acc_reg    <= '0;
        end
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            pos_reg <= div_rem;
        end
        if (state_reg == ST_CHECK)
        begin
            all_reg   <= all_reg && probe_bit;
            h_reg     <= h_reg + stride_reg;
            probe_reg <= probe_reg + 1'b1;
        end
        if ((state_reg == ST_COUNT || state_reg == ST_COUNT_LAST) && dv_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (out_load)
        begin
            out_reg <= out_new;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT_CLR;
            addr_reg      <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= (state_reg == ST_COUNT);
            if (job_pop)
            begin
                addr_reg <= '0;
            end
            else if (state_reg == ST_INIT_CLR || state_reg == ST_CLEAR
                     || state_reg == ST_COUNT)
            begin
                addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign init_busy = (state_reg == ST_INIT_CLR);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (state_reg == ST_IDLE) && !out_valid_reg)
        else $error("job taken while a result is pending");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_CHECK
            || $past(state_reg) == ST_CLEAR || $past(state_reg) == ST_COUNT_LAST)
        else $error("result raised from a wrong state");
    a_found_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.found) |-> out_reg.set_count == '0)
        else $error("found and count both set");
`endif
endmodule
`default_nettype wire

// File: hdl/bloom_filter_double_hash.sv
// top level of the bloom filter engine with its configuration registers
//
// Input channel in_valid/in_stall/in_word: one word per command (insert, query,
// clear, count) with two ready-made 64-bit base hashes. Output channel
// out_valid/out_stall/out_word: exactly one result word per command, in order.
// The filter size register sits at address 0 and the probe count register at
// address 4 on the APB port; write them only while the engine is idle.
// Insert and query with k probes: each probe starts the serial remainder unit,
// waits for the remainder, reads the store word and checks the bit, and an
// insert writes it back set; commands run one at a time.
// Clear sweeps the store one 64-bit word a cycle, W = STORE_BITS/64 words
// (1024 at default), then loads its result; count sweeps the store the same
// way, adds up the set bits of every word and loads the sum as its result.
// A two-deep queue takes new words while a result waits in the output register.
// Reset: the store is swept to zero with in_stall high; the filter size
// returns to 65536 and the probe count to 4.
// While out_stall is high the result holds and the engine stops at the next job.
`default_nettype none
module bloom_filter_double_hash #(
    parameter int STORE_BITS = bfdh_pkg::STORE_BITS_DEF,
    parameter int MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bfdh_pkg::in_word_t   in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output bfdh_pkg::out_word_t       out_word
);
    import bfdh_pkg::*;

    logic [SIZE_W-1:0]  filt_size_reg;
    logic [NHASH_W-1:0] probe_num_reg;
    logic               cfg_wr;
    logic               init_busy;
    logic               job_valid;
    logic               job_pop;
    job_t               job;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_size_reg <= SIZE_W'(65536);
            probe_num_reg <= NHASH_W'(4);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FILT_SIZE: filt_size_reg <= pwdata[SIZE_W-1:0];
                REG_PROBE_NUM: probe_num_reg <= pwdata[NHASH_W-1:0];
                default:       ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_FILT_SIZE: prdata = {{(32-SIZE_W){1'b0}}, filt_size_reg};
            REG_PROBE_NUM: prdata = {{(32-NHASH_W){1'b0}}, probe_num_reg};
            default:       prdata = '0;
        endcase
    end

    bfdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .init_busy (init_busy),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    bfdh_back #(
        .STORE_BITS (STORE_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .filt_size  (filt_size_reg),
        .probe_num  (probe_num_reg),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );
endmodule
`default_nettype wire
